// ----- rtl/fsq_pkg.sv -----
// Shared constants, payload structs and codes of the work queue with arbitrary removal.
`default_nettype none
package fsq_pkg;

	localparam int MAX_STATES = 64;
	localparam int HANDLE_BITS = 16;
	localparam int IDX_W = $clog2(MAX_STATES);
	localparam int CNT_W = $clog2(MAX_STATES + 1);
	localparam int SUM_W = CNT_W + 1;

	localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_STATES);

	typedef enum logic [1:0] {
		K_APPEND = 2'd0,
		K_REMOVE = 2'd1,
		K_MOVE   = 2'd2,
		K_SELECT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		S_OK        = 2'd0,
		S_NOT_FOUND = 2'd1,
		S_FULL      = 2'd2,
		S_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FRONT,
		ST_SEARCH,
		ST_SHIFT,
		ST_TAIL,
		ST_FINISH
	} fsq_state_t;

	typedef struct packed {
		kind_t                  kind;
		logic [HANDLE_BITS-1:0] handle;
	} req_t;

	typedef struct packed {
		logic [HANDLE_BITS-1:0] out_handle;
		status_t                status;
		logic [CNT_W-1:0]       occupancy;
	} rsp_t;

endpackage
`default_nettype wire

// ----- rtl/fsq_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module fsq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/fifo_state_queue_with_requeue.sv -----
// Top level: ordered handle queue with append, remove, move to back and select front.
//
// Requests arrive on the req channel (kind, handle) and every request yields exactly
// one beat on the rsp channel carrying a handle, a status code and the occupancy
// after the operation. Both channels use valid/ready handshakes.
// The handles live in a circular RAM with a registered read; a single
// sequencer walks it one entry per cycle.
// An append, or any request on an empty queue, goes straight to the response;
// select reads the front entry; remove walks from the front to the match and,
// unless the match is at the front or the back, shifts the later entries one place
// forward; move-to-back then writes the handle at the tail; a handle not found
// walks the whole queue. The worst case is set by the serial walk over the RAM.
// Only one request is in work at a time; a new one is accepted in the cycle after
// the previous response is loaded into the output register.
// If the receiver stalls, the response holds in the output register and the
// block finishes at most one further request, then waits before loading it.
// Reset empties the queue (head and count cleared); RAM contents are not cleared.
`default_nettype none
module fifo_state_queue_with_requeue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire fsq_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output fsq_pkg::rsp_t      rsp
);

	fsq_pkg::fsq_state_t state_q, state_d;
	fsq_pkg::req_t cmd_q, cmd_d;
	logic [fsq_pkg::CNT_W-1:0] count_q, count_d;
	logic [fsq_pkg::IDX_W-1:0] head_q, head_d;
	logic [fsq_pkg::CNT_W-1:0] pos_q, pos_d;
	logic [fsq_pkg::HANDLE_BITS-1:0] res_handle_q, res_handle_d;
	fsq_pkg::status_t res_status_q, res_status_d;
	fsq_pkg::rsp_t rsp_q, rsp_d;
	logic rsp_valid_q, rsp_valid_d;

	logic ram_we;
	logic [fsq_pkg::IDX_W-1:0] ram_waddr;
	logic [fsq_pkg::HANDLE_BITS-1:0] ram_wdata;
	logic ram_re;
	logic [fsq_pkg::IDX_W-1:0] ram_raddr;
	logic [fsq_pkg::HANDLE_BITS-1:0] ram_rdata;

	logic out_free;
	logic is_move;
	logic [fsq_pkg::CNT_W-1:0] pos_nx;
	logic [fsq_pkg::CNT_W-1:0] pos_nx2;

	// Physical slot of a queue position, wrapping around the circular store.
	function automatic logic [fsq_pkg::IDX_W-1:0] slot(
		input logic [fsq_pkg::IDX_W-1:0] base,
		input logic [fsq_pkg::CNT_W-1:0] off
	);
		logic [fsq_pkg::SUM_W-1:0] sum;
		sum = fsq_pkg::SUM_W'(base) + fsq_pkg::SUM_W'(off);
		if (sum >= fsq_pkg::SUM_W'(fsq_pkg::MAX_STATES)) begin
			sum = sum - fsq_pkg::SUM_W'(fsq_pkg::MAX_STATES);
		end
		return sum[fsq_pkg::IDX_W-1:0];
	endfunction

	fsq_ram #(
		.WIDTH(fsq_pkg::HANDLE_BITS),
		.DEPTH(fsq_pkg::MAX_STATES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign is_move   = (cmd_q.kind == fsq_pkg::K_MOVE);
	assign pos_nx    = pos_q + fsq_pkg::CNT_W'(1);
	assign pos_nx2   = pos_q + fsq_pkg::CNT_W'(2);
	assign req_ready = (state_q == fsq_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d      = state_q;
		cmd_d        = cmd_q;
		count_d      = count_q;
		head_d       = head_q;
		pos_d        = pos_q;
		res_handle_d = res_handle_q;
		res_status_d = res_status_q;
		rsp_d        = rsp_q;
		rsp_valid_d  = rsp_valid_q && !rsp_ready;
		ram_we       = 1'b0;
		ram_waddr    = slot(head_q, count_q);
		ram_wdata    = cmd_q.handle;
		ram_re       = 1'b0;
		ram_raddr    = slot(head_q, pos_nx);

		case (state_q)
			fsq_pkg::ST_IDLE: begin
				if (req_valid) begin
					cmd_d   = req;
					state_d = fsq_pkg::ST_EXEC;
				end
			end
			fsq_pkg::ST_EXEC: begin
				res_handle_d = cmd_q.handle;
				res_status_d = fsq_pkg::S_OK;
				state_d      = fsq_pkg::ST_FINISH;
				case (cmd_q.kind)
					fsq_pkg::K_APPEND: begin
						if (count_q == fsq_pkg::MAX_COUNT) begin
							res_status_d = fsq_pkg::S_FULL;
						end else begin
							ram_we  = 1'b1;
							count_d = count_q + fsq_pkg::CNT_W'(1);
						end
					end
					fsq_pkg::K_SELECT: begin
						if (count_q == '0) begin
							res_status_d = fsq_pkg::S_EMPTY;
							res_handle_d = '0;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = head_q;
							state_d   = fsq_pkg::ST_FRONT;
						end
					end
					default: begin
						if (count_q == '0) begin
							res_status_d = fsq_pkg::S_NOT_FOUND;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = head_q;
							pos_d     = '0;
							state_d   = fsq_pkg::ST_SEARCH;
						end
					end
				endcase
			end
			fsq_pkg::ST_FRONT: begin
				res_handle_d = ram_rdata;
				state_d      = fsq_pkg::ST_FINISH;
			end
			fsq_pkg::ST_SEARCH: begin
				if (ram_rdata == cmd_q.handle) begin
					if (pos_q == '0) begin
						head_d  = slot(head_q, fsq_pkg::CNT_W'(1));
						count_d = count_q - fsq_pkg::CNT_W'(1);
						state_d = is_move ? fsq_pkg::ST_TAIL : fsq_pkg::ST_FINISH;
					end else if (pos_nx == count_q) begin
						count_d = count_q - fsq_pkg::CNT_W'(1);
						state_d = is_move ? fsq_pkg::ST_TAIL : fsq_pkg::ST_FINISH;
					end else begin
						ram_re  = 1'b1;
						state_d = fsq_pkg::ST_SHIFT;
					end
				end else if (pos_nx == count_q) begin
					res_status_d = fsq_pkg::S_NOT_FOUND;
					state_d      = fsq_pkg::ST_FINISH;
				end else begin
					ram_re = 1'b1;
					pos_d  = pos_nx;
				end
			end
			fsq_pkg::ST_SHIFT: begin
				// The entry one place behind is written over the current one.
				ram_we    = 1'b1;
				ram_waddr = slot(head_q, pos_q);
				ram_wdata = ram_rdata;
				if (pos_nx2 < count_q) begin
					ram_re    = 1'b1;
					ram_raddr = slot(head_q, pos_nx2);
					pos_d     = pos_nx;
				end else begin
					count_d = count_q - fsq_pkg::CNT_W'(1);
					state_d = is_move ? fsq_pkg::ST_TAIL : fsq_pkg::ST_FINISH;
				end
			end
			fsq_pkg::ST_TAIL: begin
				ram_we  = 1'b1;
				count_d = count_q + fsq_pkg::CNT_W'(1);
				state_d = fsq_pkg::ST_FINISH;
			end
			fsq_pkg::ST_FINISH: begin
				if (out_free) begin
					rsp_valid_d     = 1'b1;
					rsp_d.out_handle = res_handle_q;
					rsp_d.status     = res_status_q;
					rsp_d.occupancy  = count_q;
					state_d          = fsq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fsq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fsq_pkg::ST_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			head_q      <= head_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q        <= cmd_d;
		pos_q        <= pos_d;
		res_handle_q <= res_handle_d;
		res_status_q <= res_status_d;
		rsp_q        <= rsp_d;
	end

endmodule
`default_nettype wire
